>>> rtl/ezpt_pkg.sv
// Package for the Euler ZYX pose transform core.
// Types, CORDIC constants and arctangent table; no dependencies.
package ezpt_pkg;
   localparam int AngW = 34;
   localparam int CsW = 33;
   localparam int AtanLen = 24;
   localparam logic signed [CsW-1:0] CordicGain = 33'sd652032874;
   localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;
   localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;

   typedef logic signed [AngW-1:0] ang_type;
   typedef logic signed [CsW-1:0] cs_type;

   typedef struct packed {
      cs_type x;
      cs_type y;
      ang_type a;
      logic flip;
   } lane_type;

   typedef struct packed {
      lane_type r;
      lane_type p;
      lane_type w;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic vld;
   } stage_type;

   function automatic ang_type atan_q30(input logic [4:0] i);
      logic [31:0] t;
      unique case (i)
         5'd0: t = 32'h3243F6A8;  5'd1: t = 32'h1DAC6705;
         5'd2: t = 32'h0FADBAFC;  5'd3: t = 32'h07F56EA6;
         5'd4: t = 32'h03FEAB76;  5'd5: t = 32'h01FFD55B;
         5'd6: t = 32'h00FFFAAA;  5'd7: t = 32'h007FFF55;
         5'd8: t = 32'h003FFFEA;  5'd9: t = 32'h001FFFFD;
         5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
         5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF;
         5'd14: t = 32'h0000FFFF; 5'd15: t = 32'h00007FFF;
         5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
         5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF;
         5'd20: t = 32'h000003FF; 5'd21: t = 32'h000001FF;
         5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
         default: t = 32'h0;
      endcase
      return ang_type'({2'b00, t});
   endfunction

   function automatic lane_type lane_init(input logic signed [15:0] ang);
      lane_type l;
      ang_type a;
      a = ang_type'(ang) <<< 17;
      l.x = CordicGain;
      l.y = '0;
      l.flip = 1'b0;
      if (a > HalfPiQ30) begin
         a = a - PiQ30;
         l.flip = 1'b1;
      end else if (a < -HalfPiQ30) begin
         a = a + PiQ30;
         l.flip = 1'b1;
      end
      l.a = a;
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l, input logic [4:0] i);
      lane_type o;
      cs_type dx;
      cs_type dy;
      dx = l.y >>> i;
      dy = l.x >>> i;
      o = l;
      if (l.a >= 0) begin
         o.x = l.x - dx;
         o.y = l.y + dy;
         o.a = l.a - atan_q30(i);
      end else begin
         o.x = l.x + dx;
         o.y = l.y - dy;
         o.a = l.a + atan_q30(i);
      end
      return o;
   endfunction

   function automatic cs_type mul30(input cs_type a, input cs_type b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + (66'sd1 <<< 29);
      return cs_type'(p >>> 30);
   endfunction

   function automatic logic signed [15:0] to_q14(input logic signed [34:0] v);
      logic signed [34:0] r;
      r = (v + 35'sd32768) >>> 16;
      if (r > 35'sd16384) r = 35'sd16384;
      if (r < -35'sd16384) r = -35'sd16384;
      return r[15:0];
   endfunction
endpackage

>>> rtl/ezpt_cell.sv
// One CORDIC iteration cell for three angle lanes plus position carry.
// Depends on ezpt_pkg.
module ezpt_cell import ezpt_pkg::*; #(
   parameter int Stage = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  stage_type d_in,
   output stage_type d_out
);
   stage_type q_ff;
   stage_type q_in;
   localparam logic [4:0] Idx = 5'(Stage);

   always_comb begin
      q_in = d_in;
      q_in.r = lane_step(d_in.r, Idx);
      q_in.p = lane_step(d_in.p, Idx);
      q_in.w = lane_step(d_in.w, Idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;
endmodule

>>> rtl/ezpt_matrix.sv
// Pipelined product tree forming the ZYX rotation matrix from sines and cosines.
// Depends on ezpt_pkg.
module ezpt_matrix import ezpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  stage_type         d_in,
   output logic              vld,
   output logic signed [15:0] m [9],
   output logic [31:0]       px,
   output logic [31:0]       py,
   output logic [31:0]       pz
);
   cs_type sr_ff, cr_ff, sp_ff, cp_ff, sy_ff, cy_ff;
   logic [2:0] v_ff;
   logic [31:0] p1_ff [3];
   logic [31:0] p2_ff [3];
   logic [31:0] p3_ff [3];
   cs_type crsp_ff, srsp_ff, cp2_ff, sy2_ff, cy2_ff, sr2_ff, cr2_ff, sp2_ff;
   cs_type t_ff [14];
   logic signed [15:0] m_ff [9];

   always_ff @(posedge clock) begin
      sr_ff <= d_in.r.flip ? -d_in.r.y : d_in.r.y;
      cr_ff <= d_in.r.flip ? -d_in.r.x : d_in.r.x;
      sp_ff <= d_in.p.flip ? -d_in.p.y : d_in.p.y;
      cp_ff <= d_in.p.flip ? -d_in.p.x : d_in.p.x;
      sy_ff <= d_in.w.flip ? -d_in.w.y : d_in.w.y;
      cy_ff <= d_in.w.flip ? -d_in.w.x : d_in.w.x;
      p1_ff <= '{d_in.px, d_in.py, d_in.pz};
      crsp_ff <= mul30(cr_ff, sp_ff);
      srsp_ff <= mul30(sr_ff, sp_ff);
      t_ff[0] <= mul30(cr_ff, cp_ff);
      t_ff[1] <= mul30(sr_ff, cy_ff);
      t_ff[2] <= mul30(sr_ff, sy_ff);
      t_ff[3] <= mul30(sr_ff, cp_ff);
      t_ff[4] <= mul30(cr_ff, cy_ff);
      t_ff[5] <= mul30(cr_ff, sy_ff);
      t_ff[6] <= mul30(cp_ff, sy_ff);
      t_ff[7] <= mul30(cp_ff, cy_ff);
      sp2_ff <= sp_ff;
      sy2_ff <= sy_ff;
      cy2_ff <= cy_ff;
      p2_ff <= p1_ff;
      t_ff[8] <= t_ff[0];
      t_ff[9] <= t_ff[3];
      t_ff[10] <= t_ff[6];
      t_ff[11] <= t_ff[7];
      t_ff[12] <= mul30(crsp_ff, sy2_ff) - t_ff[1];
      t_ff[13] <= t_ff[2] + mul30(crsp_ff, cy2_ff);
      sr2_ff <= t_ff[4] + mul30(srsp_ff, sy2_ff);
      cr2_ff <= mul30(srsp_ff, cy2_ff) - t_ff[5];
      cp2_ff <= -sp2_ff;
      p3_ff <= p2_ff;
      m_ff[0] <= to_q14(35'(t_ff[8]));
      m_ff[1] <= to_q14(35'(t_ff[12]));
      m_ff[2] <= to_q14(35'(t_ff[13]));
      m_ff[3] <= to_q14(35'(t_ff[9]));
      m_ff[4] <= to_q14(35'(sr2_ff));
      m_ff[5] <= to_q14(35'(cr2_ff));
      m_ff[6] <= to_q14(35'(cp2_ff));
      m_ff[7] <= to_q14(35'(t_ff[10]));
      m_ff[8] <= to_q14(35'(t_ff[11]));
      px <= p3_ff[0];
      py <= p3_ff[1];
      pz <= p3_ff[2];
   end

   logic vo_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         vo_ff <= 1'b0;
      end else begin
         v_ff <= {v_ff[1:0], d_in.vld};
         vo_ff <= v_ff[2];
      end
   end

   assign vld = vo_ff;
   assign m = m_ff;
endmodule

>>> rtl/euler_zyx_to_pose_transform_core.sv
// Euler ZYX pose to rotation matrix and translation: one request per cycle,
// never busy. Between the accepting edge and the edge that takes the result lie
// one input register, one CORDIC cell per iteration, then a four-stage multiply
// tree. The receiver cannot stall; each result is shown for one cycle
// with rsp_valid.
// Depends on ezpt_pkg, ezpt_cell, ezpt_matrix.
module euler_zyx_to_pose_transform_core import ezpt_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic              rsp_valid,
   output logic signed [15:0] rsp_rot_r0_c0,
   output logic signed [15:0] rsp_rot_r0_c1,
   output logic signed [15:0] rsp_rot_r0_c2,
   output logic signed [15:0] rsp_rot_r1_c0,
   output logic signed [15:0] rsp_rot_r1_c1,
   output logic signed [15:0] rsp_rot_r1_c2,
   output logic signed [15:0] rsp_rot_r2_c0,
   output logic signed [15:0] rsp_rot_r2_c1,
   output logic signed [15:0] rsp_rot_r2_c2,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z
);
   localparam int NIter = (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;

   stage_type chain [NIter+1];
   stage_type in_ff;
   stage_type in_in;
   logic signed [15:0] m [9];
   logic [31:0] px, py, pz;

   assign busy = 1'b0;

   always_comb begin
      in_in.r = lane_init(req_roll_angle);
      in_in.p = lane_init(req_pitch_angle);
      in_in.w = lane_init(req_yaw_angle);
      in_in.px = req_pos_x;
      in_in.py = req_pos_y;
      in_in.pz = req_pos_z;
      in_in.vld = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff <= '0;
      end else begin
         in_ff <= in_in;
      end
   end

   assign chain[0] = in_ff;

   for (genvar g = 0; g < NIter; g++) begin : g_cell
      ezpt_cell #(.Stage(g)) u_cell (
         .clock(clock), .reset(reset), .d_in(chain[g]), .d_out(chain[g+1])
      );
   end

   ezpt_matrix u_matrix (
      .clock(clock), .reset(reset), .d_in(chain[NIter]),
      .vld(rsp_valid), .m(m), .px(px), .py(py), .pz(pz)
   );

   assign rsp_rot_r0_c0 = m[0];
   assign rsp_rot_r0_c1 = m[1];
   assign rsp_rot_r0_c2 = m[2];
   assign rsp_rot_r1_c0 = m[3];
   assign rsp_rot_r1_c1 = m[4];
   assign rsp_rot_r1_c2 = m[5];
   assign rsp_rot_r2_c0 = m[6];
   assign rsp_rot_r2_c1 = m[7];
   assign rsp_rot_r2_c2 = m[8];
   assign rsp_trans_x = px;
   assign rsp_trans_y = py;
   assign rsp_trans_z = pz;
endmodule

>>> verif/tb_euler_zyx_to_pose_transform_core.sv
// Testbench for euler_zyx_to_pose_transform_core: random and corner-case poses,
// compared against a bit-exact CORDIC rotation-matrix predictor in a scoreboard.
// Depends on ezpt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_euler_zyx_to_pose_transform_core import ezpt_pkg::*;;

   localparam int Iters = 16;
   localparam int Latency = Iters + 6;

   typedef struct {
      logic signed [15:0] rot[9];
      logic signed [31:0] tx, ty, tz;
   } pose_mat_type;

   class pose_scoreboard;
      pose_mat_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      static function longint fshift(longint v, int s);
         return v >>> s;
      endfunction

      static function void trig(logic signed [15:0] ang, output longint s, output longint c);
         longint a, x, y, dx, dy, at;
         bit flip;
         int n;
         a = longint'(ang) * 131072;
         x = 652032874;
         y = 0;
         flip = 0;
         n = (Iters > 24) ? 24 : Iters;
         if (a > 64'sd1686629713) begin
            a -= 64'sd3373259426;
            flip = 1;
         end else if (a < -64'sd1686629713) begin
            a += 64'sd3373259426;
            flip = 1;
         end
         for (int i = 0; i < n; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            at = longint'(atan_q30(5'(i)));
            if (a >= 0) begin
               x -= dx; y += dy; a -= at;
            end else begin
               x += dx; y -= dy; a += at;
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         s = y;
         c = x;
      endfunction

      static function longint m30(longint a, longint b);
         return fshift(a * b + (longint'(1) << 29), 30);
      endfunction

      static function logic signed [15:0] q14(longint v);
         longint r;
         r = fshift(v + 32768, 16);
         if (r > 16384) r = 16384;
         if (r < -16384) r = -16384;
         return 16'(r);
      endfunction

      function void note_request(logic signed [15:0] ro, pi, ya,
                                 logic signed [31:0] px, py, pz);
         longint sr, cr, sp, cp, sy, cy, crsp, srsp;
         pose_mat_type m;
         trig(ro, sr, cr);
         trig(pi, sp, cp);
         trig(ya, sy, cy);
         crsp = m30(cr, sp);
         srsp = m30(sr, sp);
         m.rot[0] = q14(m30(cr, cp));
         m.rot[1] = q14(m30(crsp, sy) - m30(sr, cy));
         m.rot[2] = q14(m30(sr, sy) + m30(crsp, cy));
         m.rot[3] = q14(m30(sr, cp));
         m.rot[4] = q14(m30(cr, cy) + m30(srsp, sy));
         m.rot[5] = q14(m30(srsp, cy) - m30(cr, sy));
         m.rot[6] = q14(-sp);
         m.rot[7] = q14(m30(cp, sy));
         m.rot[8] = q14(m30(cp, cy));
         m.tx = px; m.ty = py; m.tz = pz;
         pending = {pending, m};
      endfunction

      function void check_result(pose_mat_type got);
         pose_mat_type e;
         if (pending.size() == 0) begin
            $error("unexpected result");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int k = 0; k < 9; k++)
            if (got.rot[k] !== e.rot[k]) begin
               $error("rot_r%0d_c%0d expected %0d actual %0d", k / 3, k % 3, e.rot[k],
                      got.rot[k]);
               errors++;
            end
         if (got.tx !== e.tx) begin
            $error("trans_x expected %0d actual %0d", e.tx, got.tx); errors++;
         end
         if (got.ty !== e.ty) begin
            $error("trans_y expected %0d actual %0d", e.ty, got.ty); errors++;
         end
         if (got.tz !== e.tz) begin
            $error("trans_z expected %0d actual %0d", e.tz, got.tz); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic signed [15:0] req_roll_angle = 0, req_pitch_angle = 0, req_yaw_angle = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic signed [31:0] tx, ty, tz;
   pose_scoreboard board;
   bit calm;

   always #1 clock = ~clock;

   euler_zyx_to_pose_transform_core #(.CORDIC_ITERATIONS(Iters)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_roll_angle(req_roll_angle), .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .rsp_valid(rsp_valid),
      .rsp_rot_r0_c0(r00), .rsp_rot_r0_c1(r01), .rsp_rot_r0_c2(r02),
      .rsp_rot_r1_c0(r10), .rsp_rot_r1_c1(r11), .rsp_rot_r1_c2(r12),
      .rsp_rot_r2_c0(r20), .rsp_rot_r2_c1(r21), .rsp_rot_r2_c2(r22),
      .rsp_trans_x(tx), .rsp_trans_y(ty), .rsp_trans_z(tz));

   always @(posedge clock) begin
      pose_mat_type got;
      if (!reset && rsp_valid) begin
         got.rot = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
         got.tx = tx; got.ty = ty; got.tz = tz;
         board.check_result(got);
      end
      if (!reset && start && !busy)
         board.note_request(req_roll_angle, req_pitch_angle, req_yaw_angle,
                            req_pos_x, req_pos_y, req_pos_z);
   end

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'(32'($urandom_range(0, 6)) * 32'h3243 / 2 - 32'h4B65 + $urandom_range(0, 4) - 2);
         1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 15'($urandom_range(0, 32767))};
         default: return 16'($urandom_range(0, 25736) - 12868);
      endcase
   endfunction

   // keeps start high across back-to-back requests; idles for a random gap unless calm is set
   task automatic send_pose(logic [15:0] ro, pi, ya, logic [31:0] px, py, pz);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_roll_angle <= ro; req_pitch_angle <= pi; req_yaw_angle <= ya;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [15:0] corner[8];
      int waited;
      corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h3244, 16'h3243, 16'hCDBC,
                 16'hCDBD};
      board = new();
      calm = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      for (int k = 0; k < 8; k++)
         send_pose(corner[k], corner[(k + 3) % 8], corner[(k + 5) % 8],
                   32'h8000_0000, 32'h7FFF_FFFF, k[0] ? 32'hFFFF_FFFF : 32'h0);
      send_pose(16'h6487, 16'h6487, 16'h9B79, 32'h0001_0000, 32'hFFFF_0000, 32'h1);
      send_pose(16'h1922, 16'hE6DE, 16'h1922, $urandom, $urandom, $urandom);
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      for (int n = 0; n < 450; n++) begin
         if (n == 380) calm = 1;
         send_pose(rand_angle(), rand_angle(), rand_angle(), $urandom, $urandom, $urandom);
      end
      start <= 0;
      waited = 0;
      while (board.pending.size() != 0 && waited < 10 * Latency) begin
         @(posedge clock);
         waited++;
      end
      repeat (Latency + 4) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #200000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> filelist.f
rtl/ezpt_pkg.sv
rtl/ezpt_cell.sv
rtl/ezpt_matrix.sv
rtl/euler_zyx_to_pose_transform_core.sv
verif/tb_euler_zyx_to_pose_transform_core.sv
